@@ hdl/sst_pkg.sv @@
// Shared types and constants for the sorted set table.
// Used by sst_ctrl, sst_datapath and sorted_set_table_unit; no dependencies.
package sst_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the ports
   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [POS_W-1:0] POSITION_MAX = {POS_W{1'b1}};

   // Command codes; the unused code acts as a lookup
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEARCH_TEST,
      ST_MID_READ,
      ST_MID_STEP,
      ST_POS_READ,
      ST_POS_CHECK,
      ST_DECIDE,
      ST_INS_INIT,
      ST_INS_TEST,
      ST_INS_READ,
      ST_INS_WRITE,
      ST_INS_PLACE,
      ST_REM_INIT,
      ST_REM_TEST,
      ST_REM_READ,
      ST_REM_WRITE,
      ST_REM_DONE,
      ST_RESPOND
   } state_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_HOLD,
      DP_LOAD,
      DP_MID_READ,
      DP_MID_STEP,
      DP_POS_READ,
      DP_POS_CHECK,
      DP_INS_INIT,
      DP_INS_READ,
      DP_INS_WRITE,
      DP_INS_PLACE,
      DP_REM_INIT,
      DP_REM_READ,
      DP_REM_WRITE,
      DP_REM_DONE,
      DP_RESPOND
   } dp_op_type;

   // Status from datapath to controller
   typedef struct packed {
      logic lo_lt_hi;
      logic member;
      logic rejected;
      logic is_insert;
      logic is_remove;
      logic ptr_gt_pos;
      logic ptr_next_lt_count;
   } status_type;

endpackage

@@ hdl/sst_ctrl.sv @@
// Controller state machine for the sorted set table.
// Depends on sst_pkg; drives the datapath operation and the busy flag.
module sst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  sst_pkg::status_type status,
   output sst_pkg::dp_op_type  op,
   output logic               busy
);
   import sst_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      op       = DP_HOLD;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               op       = DP_LOAD;
               state_in = ST_SEARCH_TEST;
            end
         end
         ST_SEARCH_TEST: begin
            state_in = status.lo_lt_hi ? ST_MID_READ : ST_POS_READ;
         end
         ST_MID_READ: begin
            op       = DP_MID_READ;
            state_in = ST_MID_STEP;
         end
         ST_MID_STEP: begin
            op       = DP_MID_STEP;
            state_in = ST_SEARCH_TEST;
         end
         ST_POS_READ: begin
            op       = DP_POS_READ;
            state_in = ST_POS_CHECK;
         end
         ST_POS_CHECK: begin
            op       = DP_POS_CHECK;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.is_insert && !status.member && !status.rejected) begin
               state_in = ST_INS_INIT;
            end else if (status.is_remove && status.member) begin
               state_in = ST_REM_INIT;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_INS_INIT: begin
            op       = DP_INS_INIT;
            state_in = ST_INS_TEST;
         end
         ST_INS_TEST: begin
            state_in = status.ptr_gt_pos ? ST_INS_READ : ST_INS_PLACE;
         end
         ST_INS_READ: begin
            op       = DP_INS_READ;
            state_in = ST_INS_WRITE;
         end
         ST_INS_WRITE: begin
            op       = DP_INS_WRITE;
            state_in = ST_INS_TEST;
         end
         ST_INS_PLACE: begin
            op       = DP_INS_PLACE;
            state_in = ST_RESPOND;
         end
         ST_REM_INIT: begin
            op       = DP_REM_INIT;
            state_in = ST_REM_TEST;
         end
         ST_REM_TEST: begin
            state_in = status.ptr_next_lt_count ? ST_REM_READ : ST_REM_DONE;
         end
         ST_REM_READ: begin
            op       = DP_REM_READ;
            state_in = ST_REM_WRITE;
         end
         ST_REM_WRITE: begin
            op       = DP_REM_WRITE;
            state_in = ST_REM_TEST;
         end
         ST_REM_DONE: begin
            op       = DP_REM_DONE;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            op       = DP_RESPOND;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/sst_datapath.sv @@
// Datapath for the sorted set table: element store, search bounds, shift pointer.
// Depends on sst_pkg; driven by sst_ctrl through a datapath operation code.
module sst_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sst_pkg::dp_op_type            op,
   input  logic [sst_pkg::CMD_W-1:0]     req_command,
   input  logic signed [sst_pkg::VALUE_W-1:0] req_value,
   output sst_pkg::status_type           status,
   output logic                          rsp_valid,
   output logic                          rsp_was_member,
   output logic [sst_pkg::POS_W-1:0]     rsp_position,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_rejected
);
   import sst_pkg::*;

   // Element store with one write and one registered read port
   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rdata_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               wr_en;

   // Command registers
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi_ff, hi_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          ptr_ff, ptr_in;
   logic                      member_ff, member_in;
   logic                      rejected_ff, rejected_in;

   // Result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_member_ff, rsp_member_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_rej_ff, rsp_rej_in;

   // Derived values
   logic [CNT_W:0]   bound_sum;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] ptr_dec;
   logic [CNT_W-1:0] ptr_inc;
   logic             entry_less;
   logic             full;

   assign bound_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = bound_sum[CNT_W:1];
   assign ptr_dec    = ptr_ff - 1'b1;
   assign ptr_inc    = ptr_ff + 1'b1;
   assign entry_less = $signed(rdata_ff) < value_ff;
   assign full       = (count_ff == CNT_W'(CAPACITY));

   // Status to the controller
   always_comb begin
      status.lo_lt_hi          = (lo_ff < hi_ff);
      status.member            = member_ff;
      status.rejected          = rejected_ff;
      status.is_insert         = (cmd_ff == CMD_INSERT);
      status.is_remove         = (cmd_ff == CMD_REMOVE);
      status.ptr_gt_pos        = (ptr_ff > lo_ff);
      status.ptr_next_lt_count = (ptr_inc < count_ff);
   end

   // Decode the operation
   always_comb begin
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      member_in     = member_ff;
      rejected_in   = rejected_ff;
      rsp_valid_in  = 1'b0;
      rsp_member_in = rsp_member_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rej_in    = rsp_rej_ff;
      rd_addr       = lo_ff[IDX_W-1:0];
      wr_addr       = ptr_ff[IDX_W-1:0];
      wr_data       = rdata_ff;
      wr_en         = 1'b0;
      unique case (op)
         DP_HOLD: begin
         end
         DP_LOAD: begin
            cmd_in      = req_command;
            value_in    = req_value;
            lo_in       = '0;
            hi_in       = count_ff;
            member_in   = 1'b0;
            rejected_in = 1'b0;
         end
         DP_MID_READ: begin
            rd_addr = mid[IDX_W-1:0];
         end
         DP_MID_STEP: begin
            if (entry_less) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         DP_POS_READ: begin
            rd_addr = lo_ff[IDX_W-1:0];
         end
         DP_POS_CHECK: begin
            member_in   = (lo_ff < count_ff) && (rdata_ff == value_ff);
            rejected_in = (cmd_ff == CMD_INSERT) && !member_in && full;
         end
         DP_INS_INIT: begin
            ptr_in = count_ff;
         end
         DP_INS_READ: begin
            rd_addr = ptr_dec[IDX_W-1:0];
         end
         DP_INS_WRITE: begin
            wr_en  = 1'b1;
            ptr_in = ptr_dec;
         end
         DP_INS_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[IDX_W-1:0];
            wr_data  = value_ff;
            count_in = count_ff + 1'b1;
         end
         DP_REM_INIT: begin
            ptr_in = lo_ff;
         end
         DP_REM_READ: begin
            rd_addr = ptr_inc[IDX_W-1:0];
         end
         DP_REM_WRITE: begin
            wr_en  = 1'b1;
            ptr_in = ptr_inc;
         end
         DP_REM_DONE: begin
            count_in = count_ff - 1'b1;
         end
         DP_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_member_in = member_ff;
            rsp_pos_in    = (lo_ff > CNT_W'(POSITION_MAX)) ? POSITION_MAX
                                                           : lo_ff[POS_W-1:0];
            rsp_count_in  = COUNT_W'(count_ff);
            rsp_rej_in    = rejected_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ptr_ff        <= ptr_in;
      member_ff     <= member_in;
      rejected_ff   <= rejected_in;
      rsp_member_ff <= rsp_member_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rej_ff    <= rsp_rej_in;
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_member = rsp_member_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

@@ hdl/sorted_set_table_unit.sv @@
// Top level of the sorted set table: a set of distinct signed values in order.
// Depends on sst_pkg, sst_ctrl and sst_datapath.
//
// Usage:
//   Request: drive req_command and req_value and raise start while busy is
//   low; the transfer happens at that clock edge. busy stays high until the
//   command is finished. Commands: insert, remove, lookup (unused code acts
//   as a lookup).
//   Result: rsp_valid is high for exactly one cycle, with rsp_was_member,
//   rsp_position, rsp_count and rsp_rejected valid in that cycle. The
//   receiver cannot stall; the result is taken at the end of that cycle.
// Sequencing:
//   The binary search reads the store's read port once per step over S
//   steps (S at most 7), each step running ST_SEARCH_TEST, ST_MID_READ and
//   ST_MID_STEP. An insert or remove that changes the set then moves M
//   entries one at a time through the store (at most 63). The result strobe
//   comes in the cycle in which busy falls, and the next command can be
//   taken then.
// Reset:
//   Synchronous reset empties the set (count zero) and idles the controller;
//   the store contents are not cleared, only entries below the count are used.
module sorted_set_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sst_pkg::CMD_W-1:0]           req_command,
   input  logic signed [sst_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic                                rsp_was_member,
   output logic [sst_pkg::POS_W-1:0]           rsp_position,
   output logic [sst_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_rejected
);
   import sst_pkg::*;

   dp_op_type  op;
   status_type status;

   // Controller
   sst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   // Datapath
   sst_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .req_command    (req_command),
      .req_value      (req_value),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_was_member (rsp_was_member),
      .rsp_position   (rsp_position),
      .rsp_count      (rsp_count),
      .rsp_rejected   (rsp_rejected)
   );

   // A result only appears once the controller is back to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted command always occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // Count never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= COUNT_W'(CAPACITY)))
      else $error("count above capacity");

   // A rejection only happens on a full store for a new value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |->
         ((rsp_count == COUNT_W'(CAPACITY)) && !rsp_was_member))
      else $error("rejection without full store");

endmodule
